// ----- rtl/kwm_pkg.sv -----
`timescale 1ns / 1ps
package kwm_pkg;

   // element and field widths
   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int ID_W     = 3;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_POPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_ADV,
      S_FILL
   } kwm_state_type;

endpackage

// ----- rtl/kwm_store.sv -----
`timescale 1ns / 1ps
module kwm_store import kwm_pkg::*; #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [VALUE_W-1:0]  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [VALUE_W-1:0]  rd_data
);

   // shared element memory, one write and one registered read per cycle
   logic [VALUE_W-1:0] elem_mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         elem_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= elem_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/kwm_min.sv -----
`timescale 1ns / 1ps
module kwm_min import kwm_pkg::*; #(
   parameter int LIST_COUNT = 8,
   parameter int LIST_W     = 3
) (
   input  logic signed [VALUE_W-1:0] head_val [LIST_COUNT],
   input  logic [LIST_COUNT-1:0]     nonempty,
   output logic                      found,
   output logic [LIST_W-1:0]         best_idx,
   output logic signed [VALUE_W-1:0] best_val
);

   // heap-ordered compare tree; leaves padded up to a power of two
   localparam int LEAVES = 1 << LIST_W;
   localparam int NODES  = 2 * LEAVES - 1;

   logic                      node_ok  [NODES];
   logic [LIST_W-1:0]         node_idx [NODES];
   logic signed [VALUE_W-1:0] node_val [NODES];

   // leaves: one per list, unused slots never win
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < LIST_COUNT) begin : g_used
         assign node_ok[LEAVES-1+i]  = nonempty[i];
         assign node_val[LEAVES-1+i] = head_val[i];
      end else begin : g_pad
         assign node_ok[LEAVES-1+i]  = 1'b0;
         assign node_val[LEAVES-1+i] = '0;
      end
      assign node_idx[LEAVES-1+i] = LIST_W'(i);
   end

   // inner nodes: lower list wins on a tie
   for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      logic take_left;
      assign take_left = node_ok[2*n+1] &&
                         (!node_ok[2*n+2] || (node_val[2*n+1] <= node_val[2*n+2]));
      assign node_ok[n]  = node_ok[2*n+1] || node_ok[2*n+2];
      assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
      assign node_val[n] = take_left ? node_val[2*n+1] : node_val[2*n+2];
   end

   assign found    = node_ok[0];
   assign best_idx = node_idx[0];
   assign best_val = node_val[0];

endmodule

// ----- rtl/k_way_sorted_merge_top.sv -----
`timescale 1ns / 1ps
// K-way merge of sorted lists.
// Request channel (req_): tuser carries opcode and list_id, tdata the value.
// Opcode append adds the value at the tail of the named list, pop returns the
// smallest head over all non-empty lists and advances that list, clear empties
// every list. Each request produces exactly one response on the rsp_ channel:
// tdata holds the popped value (zero otherwise), tuser the status.
// Requests are handled one at a time by a small sequencer around one element
// memory; the head of each list is cached in registers next to a compare tree.
// The response is registered by the execute step that follows acceptance.
// Append, clear and empty pop: accept, then execute.
// Successful pop: accept, select minimum, advance head and read the next
// element from memory, then load it into the head cache from the registered
// memory read. A pop that takes the last element of its list skips the read
// and the load.
// The response sits in an output register; a new request is accepted while it
// waits, and only the execute step holds when that register is still full.
// Reset (synchronous) empties all lists and drops any pending response; the
// element memory is not cleared, so the block is ready on the next cycle.
module k_way_sorted_merge_top import kwm_pkg::*; #(
   parameter int LIST_COUNT = 8,
   parameter int LIST_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,   // [31:0] value
   input  logic [4:0]          req_tuser,   // [1:0] opcode, [4:2] list_id
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [VALUE_W-1:0]  rsp_tdata,   // [31:0] result_value
   output logic [STATUS_W-1:0] rsp_tuser    // [1:0] status
);

   localparam int IDX_W0  = $clog2(LIST_DEPTH);
   localparam int IDX_W   = (IDX_W0 < 1) ? 1 : IDX_W0;
   localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
   localparam int LIST_W0 = $clog2(LIST_COUNT);
   localparam int LIST_W  = (LIST_W0 < 1) ? 1 : LIST_W0;
   localparam int MEM_D   = LIST_COUNT * LIST_DEPTH;
   localparam int ADDR_W0 = $clog2(MEM_D);
   localparam int ADDR_W  = (ADDR_W0 < 1) ? 1 : ADDR_W0;

   // sequencer and request registers
   kwm_state_type state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [LIST_W-1:0]  best_ff, best_in;

   // per-list state
   logic [IDX_W-1:0]          head_idx_ff [LIST_COUNT];
   logic [IDX_W-1:0]          head_idx_in [LIST_COUNT];
   logic [CNT_W-1:0]          fill_ff     [LIST_COUNT];
   logic [CNT_W-1:0]          fill_in     [LIST_COUNT];
   logic signed [VALUE_W-1:0] head_val_ff [LIST_COUNT];
   logic signed [VALUE_W-1:0] head_val_in [LIST_COUNT];
   logic [LIST_COUNT-1:0]     nonempty;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_load;
   logic                out_free;

   // memory ports
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data, rd_data;

   // minimum select
   logic                      found;
   logic [LIST_W-1:0]         sel_idx;
   logic signed [VALUE_W-1:0] sel_val;

   // append address path
   logic [6:0]         id_ext;
   logic [LIST_W-1:0]  app_list;
   logic               id_ok;
   logic [IDX_W:0]     pos_sum;
   logic [IDX_W-1:0]   app_pos;
   logic               app_full;

   // pop advance path
   logic [IDX_W:0]     nh_sum;
   logic [IDX_W-1:0]   nh_pos;

   for (genvar i = 0; i < LIST_COUNT; i++) begin : g_ne
      assign nonempty[i] = (fill_ff[i] != '0);
   end

   kwm_store #(
      .DEPTH  (MEM_D),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kwm_min #(
      .LIST_COUNT (LIST_COUNT),
      .LIST_W     (LIST_W)
   ) u_min (
      .head_val (head_val_ff),
      .nonempty (nonempty),
      .found    (found),
      .best_idx (sel_idx),
      .best_val (sel_val)
   );

   // tail position of the addressed list, wrapped into its segment
   assign id_ext   = 7'(id_ff);
   assign app_list = id_ext[LIST_W-1:0];
   assign id_ok    = (id_ext < 7'(LIST_COUNT));
   assign app_full = !id_ok || (fill_ff[app_list] == CNT_W'(LIST_DEPTH));
   assign pos_sum  = (IDX_W+1)'(head_idx_ff[app_list]) + (IDX_W+1)'(fill_ff[app_list]);
   assign app_pos  = (pos_sum >= (IDX_W+1)'(LIST_DEPTH))
                     ? IDX_W'(pos_sum - (IDX_W+1)'(LIST_DEPTH)) : IDX_W'(pos_sum);

   // next head position of the list that was popped
   assign nh_sum = (IDX_W+1)'(head_idx_ff[best_ff]) + (IDX_W+1)'(1);
   assign nh_pos = (nh_sum >= (IDX_W+1)'(LIST_DEPTH))
                   ? IDX_W'(nh_sum - (IDX_W+1)'(LIST_DEPTH)) : IDX_W'(nh_sum);

   assign out_free = !rsp_valid_ff || rsp_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LIST_COUNT; i++) begin
            head_idx_ff[i] <= '0;
            fill_ff[i]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_idx_ff  <= head_idx_in;
         fill_ff      <= fill_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      val_ff        <= val_in;
      best_ff       <= best_in;
      head_val_ff   <= head_val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      val_in        = val_ff;
      best_in       = best_ff;
      head_idx_in   = head_idx_ff;
      fill_in       = fill_ff;
      head_val_in   = head_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_load      = 1'b0;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(app_list) * ADDR_W'(LIST_DEPTH) + ADDR_W'(app_pos);
      wr_data       = val_ff;
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'(best_ff) * ADDR_W'(LIST_DEPTH) + ADDR_W'(nh_pos);

      case (state_ff)
         S_IDLE: begin
            // no request is taken while reset is held
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               op_in    = req_tuser[1:0];
               id_in    = req_tuser[4:2];
               val_in   = req_tdata;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STAT_DONE;
               state_in      = S_IDLE;
               case (op_ff)
                  OP_APPEND: begin
                     if (app_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en = 1'b1;
                        fill_in[app_list] = fill_ff[app_list] + CNT_W'(1);
                        // first element of an empty list goes straight to the head cache
                        if (fill_ff[app_list] == '0) begin
                           head_val_in[app_list] = val_ff;
                        end
                     end
                  end
                  OP_POP: begin
                     if (found) begin
                        rsp_value_in  = sel_val;
                        rsp_status_in = STAT_POPPED;
                        best_in       = sel_idx;
                        state_in      = S_ADV;
                     end else begin
                        rsp_status_in = STAT_EMPTY;
                     end
                  end
                  OP_CLEAR: begin
                     for (int i = 0; i < LIST_COUNT; i++) begin
                        head_idx_in[i] = '0;
                        fill_in[i]     = '0;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_DONE;
                  end
               endcase
            end
         end

         S_ADV: begin
            head_idx_in[best_ff] = nh_pos;
            fill_in[best_ff]     = fill_ff[best_ff] - CNT_W'(1);
            // refill the head cache when elements remain
            if (fill_ff[best_ff] > CNT_W'(1)) begin
               rd_en    = 1'b1;
               state_in = S_FILL;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_FILL: begin
            head_val_in[best_ff] = rd_data;
            state_in             = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   // head cache refill only follows a memory read in the previous cycle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> $past(rd_en))
      else $error("head refill without a preceding memory read");

   // a new response never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten while stalled");

   // fill count of list zero stays within its segment
   assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= CNT_W'(LIST_DEPTH))
      else $error("list fill count above depth");

   // a successful pop always moves on to advance the selected list
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_status_in == STAT_POPPED |=> state_ff == S_ADV)
      else $error("pop response without head advance");

endmodule

// ----- tb/tb_k_way_sorted_merge_top.sv -----
`timescale 1ns / 1ps
module tb_k_way_sorted_merge_top;
   import kwm_pkg::*;

   localparam int LISTS       = 8;
   localparam int DEPTH       = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 80;
   localparam int MAX_PRINTS  = 20;

   // opcode value the block does not define
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata  = '0;   // [31:0] value
   logic [4:0]          req_tuser  = '0;   // [1:0] opcode, [4:2] list_id
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [VALUE_W-1:0]  rsp_tdata;         // [31:0] result_value
   logic [STATUS_W-1:0] rsp_tuser;         // [1:0] status

   // predicted list contents, head pointers and fill levels
   logic [VALUE_W-1:0]  list_mem [LISTS][DEPTH];
   int unsigned         head_pos [LISTS];
   int unsigned         fill_level [LISTS];

   // responses still owed by the block, oldest first
   logic [VALUE_W-1:0]  pending_value [$];
   logic [STATUS_W-1:0] pending_status [$];

   int unsigned         error_count    = 0;
   int unsigned         send_idle_pct  = 0;
   int unsigned         recv_stall_pct = 0;
   int unsigned         cycle_count    = 0;
   logic                hold_active    = 1'b0;
   event                hold_go;

   k_way_sorted_merge_top #(
      .LIST_COUNT(LISTS),
      .LIST_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTS)
         $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // empty every list of the prediction
   function automatic void clear_lists();
      int i;
      for (i = 0; i < LISTS; i++) begin
         head_pos[i] = 0;
         fill_level[i] = 0;
      end
   endfunction

   // apply one accepted request to the prediction, queue its response
   function automatic void merge_step(input logic [OP_W-1:0] op,
                                      input logic [ID_W-1:0] id,
                                      input logic [VALUE_W-1:0] val);
      logic [VALUE_W-1:0]  res;
      logic [STATUS_W-1:0] st;
      int                  best;
      int                  i;
      int unsigned         slot;
      res = '0;
      st = STAT_DONE;
      best = -1;
      case (op)
         OP_APPEND: begin
            if (id >= LISTS || fill_level[id] >= DEPTH) begin
               st = STAT_FULL;
            end else begin
               slot = (head_pos[id] + fill_level[id]) % DEPTH;
               list_mem[id][slot] = val;
               fill_level[id]++;
            end
         end
         OP_POP: begin
            // strict compare keeps the lowest list on equal heads
            for (i = 0; i < LISTS; i++)
               if (fill_level[i] != 0 && (best < 0 ||
                   $signed(list_mem[i][head_pos[i]]) <
                   $signed(list_mem[best][head_pos[best]])))
                  best = i;
            if (best < 0) begin
               st = STAT_EMPTY;
            end else begin
               res = list_mem[best][head_pos[best]];
               head_pos[best] = (head_pos[best] + 1) % DEPTH;
               fill_level[best]--;
               st = STAT_POPPED;
            end
         end
         OP_CLEAR: clear_lists();
         default: st = STAT_DONE;
      endcase
      pending_value.push_back(res);
      pending_status.push_back(st);
   endfunction

   // offer one request, hold it until accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [VALUE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= {id, op};
      do @(posedge clock); while (!req_tready);
      merge_step(op, id, val);
   endtask

   // stop offering and wait for every owed response
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_value.size() != 0) @(posedge clock);
   endtask

   // receiver ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_active)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off, counted here
   initial begin
      forever begin
         @(hold_go);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_response
      logic [VALUE_W-1:0]  want_value;
      logic [STATUS_W-1:0] want_status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_value.size() == 0) begin
            report_mismatch("response with none pending", rsp_tdata, '0);
         end else begin
            want_value = pending_value.pop_front();
            want_status = pending_status.pop_front();
            if (rsp_tdata !== want_value)
               report_mismatch("result_value", rsp_tdata, want_value);
            if (rsp_tuser !== want_status)
               report_mismatch("status", 32'(rsp_tuser), 32'(want_status));
         end
      end
   end

   // extremes, every opcode, ties, empty pop, clear
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(OP_POP, 3'd0, 32'h0);             // all lists empty
      send_request(OP_APPEND, 3'd0, 32'h8000_0000);  // most negative
      send_request(OP_APPEND, 3'd0, 32'hFFFF_FFFF);
      send_request(OP_APPEND, 3'd7, 32'h7FFF_FFFF);  // most positive
      send_request(OP_APPEND, 3'd2, 32'd5);
      send_request(OP_APPEND, 3'd5, 32'd5);          // equal heads on 2 and 5
      send_request(OP_APPEND, 3'd2, 32'd9);
      send_request(OP_APPEND, 3'd5, 32'd9);
      send_request(OP_UNUSED, 3'd6, 32'hA5A5_A5A5);  // no effect
      repeat (8) send_request(OP_POP, 3'd7, 32'hFFFF_FFFF);
      send_request(OP_APPEND, 3'd4, 32'd1);
      send_request(OP_APPEND, 3'd4, 32'd3);
      send_request(OP_APPEND, 3'd1, 32'd2);
      send_request(OP_CLEAR, 3'd0, 32'h0);
      send_request(OP_POP, 3'd0, 32'h0);             // empty after clear
      send_request(OP_APPEND, 3'd3, 32'h0);
      send_request(OP_POP, 3'd0, 32'h0);
   endtask

   // fill one list, overflow it, wrap its pointers
   task automatic test_full_list();
      int i;
      for (i = 0; i < DEPTH; i++)
         send_request(OP_APPEND, 3'd6, 32'(i * 3 - 100));
      send_request(OP_APPEND, 3'd6, 32'd500);        // refused
      repeat (10) send_request(OP_POP, 3'd0, 32'h0);
      for (i = 0; i < 10; i++)
         send_request(OP_APPEND, 3'd6, 32'(200 + i));
      send_request(OP_APPEND, 3'd6, 32'd900);        // refused again
      repeat (DEPTH + 1) send_request(OP_POP, 3'd0, 32'h0);
      wait_drain();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_receiver_hold();
      -> hold_go;
      repeat (24)
         send_request(OP_W'($urandom_range(2)), ID_W'($urandom_range(LISTS - 1)),
                      $urandom);
      wait_drain();
   endtask

   // ascending runs into random lists, then pops through the merge
   task automatic merge_round(inout int sent);
      int               lists_used;
      int               n;
      int               k;
      int               j;
      int               total;
      int               pops;
      bit               cut_short;
      logic [ID_W-1:0]  id;
      longint           level;
      longint           stride;
      total = 0;
      lists_used = $urandom_range(LISTS, 1);
      for (k = 0; k < lists_used; k++) begin
         id = ID_W'($urandom_range(LISTS - 1));
         n = ($urandom_range(19) == 0) ? $urandom_range(DEPTH + 2, DEPTH - 4)
                                        : $urandom_range(10);
         case ($urandom_range(3))
            0: level = -64'sd2147483648 + longint'($urandom_range(8));
            1: level = 64'sd2147483647 - longint'($urandom_range(400));
            2: level = longint'($urandom_range(6));
            default: level = longint'($signed($urandom));
         endcase
         for (j = 0; j < n; j++) begin
            send_request(OP_APPEND, id, level[31:0]);
            case ($urandom_range(3))
               0: stride = 0;
               1: stride = longint'($urandom_range(3));
               2: stride = longint'($urandom_range(1000));
               default: stride = longint'($urandom_range(32'h0FFF_FFFF));
            endcase
            level = level + stride;
            if (level > 64'sd2147483647) level = 64'sd2147483647;
         end
         total += n;
      end
      cut_short = ($urandom_range(9) == 0);
      pops = cut_short ? $urandom_range(total) : total + $urandom_range(2);
      for (j = 0; j < pops; j++)
         send_request(OP_POP, ID_W'($urandom_range(LISTS - 1)), $urandom);
      if (cut_short)
         send_request(OP_CLEAR, ID_W'($urandom_range(LISTS - 1)), $urandom);
      sent += total + pops + (cut_short ? 1 : 0);
   endtask

   // random phases over the idling patterns, draining between phases
   task automatic test_random_merge();
      int unsigned idle_by_phase [4];
      int unsigned stall_by_phase [4];
      int          p;
      int          sent;
      idle_by_phase = '{0, 86, 0, 6};
      stall_by_phase = '{0, 0, 86, 6};
      for (p = 0; p < 4; p++) begin
         send_idle_pct = idle_by_phase[p];
         recv_stall_pct = stall_by_phase[p];
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 80) begin
               merge_round(sent);
            end else begin
               send_request(OP_W'($urandom_range(3)), ID_W'($urandom_range(LISTS - 1)),
                            $urandom);
               sent++;
            end
         end
         wait_drain();
      end
   endtask

   initial begin
      clear_lists();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_receiver_hold();
      test_random_merge();
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/kwm_pkg.sv
rtl/kwm_store.sv
rtl/kwm_min.sv
rtl/k_way_sorted_merge_top.sv
tb/tb_k_way_sorted_merge_top.sv
